// File: hdl/gpb_pkg.sv
// shared types, register map and divide-by-15 helper for the glyph pixel blender
package gpb_pkg;

  // register indexes on the config port (byte address is 4 * index)
  localparam logic [1:0] REG_FG    = 2'd0;
  localparam logic [1:0] REG_BG    = 2'd1;
  localparam logic [1:0] REG_WIDTH = 2'd2;
  localparam logic [1:0] REG_TOP   = 2'd3;

  localparam int unsigned CfgAddrW = 4;

  // reset values of the config registers
  localparam logic [15:0] FG_RESET    = 16'hFFFF;
  localparam logic [15:0] BG_RESET    = 16'h0000;
  localparam logic [6:0]  WIDTH_RESET = 7'd8;
  localparam logic [8:0]  TOP_RESET   = 9'd0;

  // reciprocal of 15 in 15 fractional bits, exact for sums up to 15 * 63
  localparam logic [11:0] RECIP15    = 12'd2185;
  localparam int unsigned Recip15Sh  = 15;

  // unscaled channel mixes a*fg + (15-a)*bg
  typedef struct packed {
    logic [8:0] r;
    logic [9:0] g;
    logic [8:0] b;
  } mix_t;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    mix_t       mix;
  } pix_t;

  // both pixels of one glyph byte, high nibble in hi
  typedef struct packed {
    pix_t hi;
    pix_t lo;
  } pair_t;

  // floor(v / 15) for v <= 945
  function automatic logic [5:0] div15(input logic [9:0] v);
    logic [21:0] prod;
    prod = 22'(v) * 22'(RECIP15);
    return prod[Recip15Sh +: 6];
  endfunction

endpackage

// File: hdl/gpb_if.sv
// valid/ready channel interfaces for glyph bytes in and pixels out
interface gpb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] glyph_byte;
  logic       glyph_start;
  logic [8:0] glyph_left;

  modport source (output valid, output glyph_byte, output glyph_start, output glyph_left,
                  input ready);
  modport sink (input valid, input glyph_byte, input glyph_start, input glyph_left,
                output ready);
endinterface

interface gpb_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic [15:0] pixel_color;
  logic        second_of_pair;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  output second_of_pair, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input pixel_color,
                input second_of_pair, output ready);
endinterface

// File: hdl/gpb_lane.sv
// one blend lane: weighted channel sums of fg and bg for one coverage nibble
module gpb_lane (
  input  logic [3:0]   nibble_i,
  input  logic [15:0]  fg_i,
  input  logic [15:0]  bg_i,
  output gpb_pkg::mix_t mix_o
);
  import gpb_pkg::*;

  logic [3:0] a;
  logic [3:0] na;

  // coverage is the inverted nibble
  assign a  = 4'hF - nibble_i;
  assign na = 4'hF - a;

  assign mix_o.r = 9'(a) * 9'(fg_i[15:11]) + 9'(na) * 9'(bg_i[15:11]);
  assign mix_o.g = 10'(a) * 10'(fg_i[10:5]) + 10'(na) * 10'(bg_i[10:5]);
  assign mix_o.b = 9'(a) * 9'(fg_i[4:0]) + 9'(na) * 9'(bg_i[4:0]);
endmodule

// File: hdl/gpb_merge.sv
// pair buffer and serializer: holds both lane results, scales and sends one pixel a beat
module gpb_merge (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  gpb_pkg::pair_t pair_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [9:0]     out_x_o,
  output logic [9:0]     out_y_o,
  output logic [15:0]    out_color_o,
  output logic           out_second_o
);
  import gpb_pkg::*;

  pair_t pair_q;
  logic  pair_v_q;
  logic  sel_q;
  logic  out_v_q;
  logic  out_load;
  logic  drain;
  pix_t  cur;

  logic [9:0]  x_q;
  logic [9:0]  y_q;
  logic [15:0] color_q;
  logic        second_q;
  logic [5:0]  r6;
  logic [5:0]  g6;
  logic [5:0]  b6;

  assign out_load = pair_v_q && (!out_v_q || out_ready_i);
  assign drain    = out_load && sel_q;
  assign ready_o  = !pair_v_q || drain;

  assign cur = sel_q ? pair_q.lo : pair_q.hi;
  assign r6  = div15(10'(cur.mix.r));
  assign g6  = div15(cur.mix.g);
  assign b6  = div15(10'(cur.mix.b));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_v_q <= 1'b0;
      sel_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (load_i) begin
        pair_v_q <= 1'b1;
        sel_q    <= 1'b0;
      end else if (drain) begin
        pair_v_q <= 1'b0;
        sel_q    <= 1'b0;
      end else if (out_load) begin
        sel_q <= 1'b1;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pair_q <= pair_i;
    end
    if (out_load) begin
      x_q      <= cur.x;
      y_q      <= cur.y;
      color_q  <= {r6[4:0], g6, b6[4:0]};
      second_q <= sel_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_x_o      = x_q;
  assign out_y_o      = y_q;
  assign out_color_o  = color_q;
  assign out_second_o = second_q;
endmodule

// File: hdl/glyph_pixel_blend_rgb565_core.sv
// top level of the antialiased glyph pixel blender, RGB565
//
//  channel   dir  handshake      payload
//  glyph_i   in   valid/ready    glyph_byte[7:0], glyph_start, glyph_left[8:0]
//  pixel_o   out  valid/ready    pixel_x[9:0], pixel_y[9:0], pixel_color[15:0],
//                                second_of_pair
//  apb       in   psel/penable   paddr[3:0], pwdata[31:0], prdata[31:0], pready
//
//  one glyph byte becomes two pixels; the pixel port sends one per cycle while
//  ready is high, through the single output register; bytes go in at half that rate
//  an accepted byte goes through the pair buffer and then the output register
//  the pair buffer takes the next byte in the cycle its last pixel moves out
//  reset zeroes the glyph walk and loads the config reset values; no clearing pass
//  a stalled pixel port holds the output beat and backs up into glyph_i.ready
module glyph_pixel_blend_rgb565_core #(
  parameter int unsigned MAX_GLYPH_WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  gpb_in_if.sink                   glyph_i,
  gpb_out_if.source                pixel_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [gpb_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import gpb_pkg::*;

  // column offset bits, and width bits able to hold MAX_GLYPH_WIDTH itself
  localparam int unsigned CW = (MAX_GLYPH_WIDTH > 1) ? $clog2(MAX_GLYPH_WIDTH) : 1;
  localparam int unsigned WW = CW + 1;

  // config registers
  logic [15:0] fg_q;
  logic [15:0] bg_q;
  logic [6:0]  width_q;
  logic [8:0]  top_q;
  logic        cfg_wr;

  // glyph walk state
  logic [CW-1:0] col_q, col_d;
  logic [8:0]    row_q, row_d;

  logic [WW-1:0] eff_w;
  logic [CW-1:0] col0, col1;
  logic [8:0]    row0, row1;
  logic [WW-1:0] cnext0, cnext1;
  logic          wrap0, wrap1;

  logic  accept;
  logic  in_ready;
  pair_t pair;
  mix_t  mix_hi, mix_lo;

  // apb: writes land in the access phase, pready tied high
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q    <= FG_RESET;
      bg_q    <= BG_RESET;
      width_q <= WIDTH_RESET;
      top_q   <= TOP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FG:    fg_q    <= pwdata[15:0];
        REG_BG:    bg_q    <= pwdata[15:0];
        REG_WIDTH: width_q <= pwdata[6:0];
        REG_TOP:   top_q   <= pwdata[8:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FG:    prdata = 32'(fg_q);
      REG_BG:    prdata = 32'(bg_q);
      REG_WIDTH: prdata = 32'(width_q);
      REG_TOP:   prdata = 32'(top_q);
      default:   prdata = '0;
    endcase
  end

  // width clamp: zero acts as one, above the max acts as the max
  always_comb begin
    if (32'(width_q) > MAX_GLYPH_WIDTH) begin
      eff_w = WW'(MAX_GLYPH_WIDTH);
    end else if (width_q == 7'd0) begin
      eff_w = WW'(1);
    end else begin
      eff_w = WW'(width_q);
    end
  end

  // walk two pixels per byte; a start byte restarts the glyph at its top-left
  always_comb begin
    col0   = glyph_i.glyph_start ? '0 : col_q;
    row0   = glyph_i.glyph_start ? '0 : row_q;
    cnext0 = WW'(col0) + WW'(1);
    wrap0  = cnext0 >= eff_w;
    col1   = wrap0 ? '0 : cnext0[CW-1:0];
    row1   = wrap0 ? row0 + 9'd1 : row0;
    cnext1 = WW'(col1) + WW'(1);
    wrap1  = cnext1 >= eff_w;
    col_d  = wrap1 ? '0 : cnext1[CW-1:0];
    row_d  = wrap1 ? row1 + 9'd1 : row1;
  end

  assign accept = glyph_i.valid && in_ready;
  assign glyph_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // two lanes blend the high and low nibble side by side
  gpb_lane u_lane_hi (
    .nibble_i (glyph_i.glyph_byte[7:4]),
    .fg_i     (fg_q),
    .bg_i     (bg_q),
    .mix_o    (mix_hi)
  );

  gpb_lane u_lane_lo (
    .nibble_i (glyph_i.glyph_byte[3:0]),
    .fg_i     (fg_q),
    .bg_i     (bg_q),
    .mix_o    (mix_lo)
  );

  // screen coordinates wrap at 1024
  assign pair.hi.x   = 10'(glyph_i.glyph_left) + 10'(col0);
  assign pair.hi.y   = 10'(top_q) + 10'(row0);
  assign pair.hi.mix = mix_hi;
  assign pair.lo.x   = 10'(glyph_i.glyph_left) + 10'(col1);
  assign pair.lo.y   = 10'(top_q) + 10'(row1);
  assign pair.lo.mix = mix_lo;

  gpb_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .pair_i       (pair),
    .ready_o      (in_ready),
    .out_valid_o  (pixel_o.valid),
    .out_ready_i  (pixel_o.ready),
    .out_x_o      (pixel_o.pixel_x),
    .out_y_o      (pixel_o.pixel_y),
    .out_color_o  (pixel_o.pixel_color),
    .out_second_o (pixel_o.second_of_pair)
  );
endmodule

// File: hdl/gpb_checker.sv
// port-level checks for the glyph pixel blender, bound to the top level
module gpb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_second,
  input logic pready
);
  logic [2:0] pend_q, pend_d;
  logic       exp_second_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // pixels owed: two per byte taken, one per pixel beat
  always_comb begin
    pend_d = pend_q;
    if (in_acc) begin
      pend_d = pend_d + 3'd2;
    end
    if (out_acc) begin
      pend_d = pend_d - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      exp_second_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_acc) begin
        exp_second_q <= !exp_second_q;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel beat dropped while stalled");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_second == exp_second_q)
    else $error("pixels of a byte out of order");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pend_q != 3'd0)
    else $error("pixel beat with no byte behind it");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more pixels owed than the block can hold");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("config port not ready");
endmodule

bind glyph_pixel_blend_rgb565_core gpb_checker u_gpb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (glyph_i.valid),
  .in_ready   (glyph_i.ready),
  .out_valid  (pixel_o.valid),
  .out_ready  (pixel_o.ready),
  .out_second (pixel_o.second_of_pair),
  .pready     (pready)
);

// File: verif/gpb_pixel_check.sv
// pixel checker for the glyph blender: mirrors config writes, predicts pixel beats, compares
module gpb_pixel_check #(
  parameter int unsigned MAX_GLYPH_WIDTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gpb_in_if                            glyph_i,
  gpb_out_if                           pixel_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [gpb_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  pixels_checked_o
);
  import gpb_pkg::*;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] color;
    logic        second;
  } pixel_beat_t;

  logic [15:0] fg_q;
  logic [15:0] bg_q;
  logic [6:0]  width_q;
  logic [8:0]  text_top_q;
  logic [5:0]  col_q;
  logic [8:0]  row_q;

  pixel_beat_t expected_pixels[$];

  function automatic int unsigned mix_chan(int unsigned a, int unsigned f, int unsigned b);
    return (a * f + (15 - a) * b) / 15;
  endfunction

  function automatic logic [15:0] blend565(logic [3:0] nib);
    int unsigned a;
    logic [4:0]  r;
    logic [5:0]  g;
    logic [4:0]  b;
    a = 15 - int'(nib);
    r = 5'(mix_chan(a, 32'(fg_q[15:11]), 32'(bg_q[15:11])));
    g = 6'(mix_chan(a, 32'(fg_q[10:5]), 32'(bg_q[10:5])));
    b = 5'(mix_chan(a, 32'(fg_q[4:0]), 32'(bg_q[4:0])));
    return {r, g, b};
  endfunction

  // width 0 behaves as 1, anything above the maximum is clamped
  function automatic int unsigned wrap_width(logic [6:0] w);
    if (w == '0) return 1;
    if (int'(w) > MAX_GLYPH_WIDTH) return MAX_GLYPH_WIDTH;
    return int'(w);
  endfunction

  task automatic predict_pixel(logic [8:0] left, logic [3:0] nib, logic second);
    pixel_beat_t p;
    int unsigned nxt;
    p.x      = 10'(left) + 10'(col_q);
    p.y      = 10'(text_top_q) + 10'(row_q);
    p.color  = blend565(nib);
    p.second = second;
    expected_pixels.push_back(p);
    nxt = int'(col_q) + 1;
    if (nxt >= wrap_width(width_q)) begin
      col_q = '0;
      row_q = row_q + 9'd1;
    end else begin
      col_q = 6'(nxt);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_beat_t want;
    pixel_beat_t got;
    if (!rst_ni) begin
      fg_q             = FG_RESET;
      bg_q             = BG_RESET;
      width_q          = WIDTH_RESET;
      text_top_q       = TOP_RESET;
      col_q            = '0;
      row_q            = '0;
      expected_pixels.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      pixels_checked_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CfgAddrW-1:2])
          REG_FG:    fg_q       = pwdata[15:0];
          REG_BG:    bg_q       = pwdata[15:0];
          REG_WIDTH: width_q    = pwdata[6:0];
          REG_TOP:   text_top_q = pwdata[8:0];
          default: ;
        endcase
      end

      if (pixel_i.valid && pixel_i.ready) begin
        got.x      = pixel_i.pixel_x;
        got.y      = pixel_i.pixel_y;
        got.color  = pixel_i.pixel_color;
        got.second = pixel_i.second_of_pair;
        if (expected_pixels.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("pixel beat %0d: none expected, got x=%0d y=%0d color=%04h second=%0b",
                     pixels_checked_o, got.x, got.y, got.color, got.second);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display({"pixel beat %0d: expected x=%0d y=%0d color=%04h second=%0b,",
                        " got x=%0d y=%0d color=%04h second=%0b"},
                       pixels_checked_o, want.x, want.y, want.color, want.second,
                       got.x, got.y, got.color, got.second);
          end
        end
        pixels_checked_o++;
      end

      if (glyph_i.valid && glyph_i.ready) begin
        if (glyph_i.glyph_start) begin
          col_q = '0;
          row_q = '0;
        end
        predict_pixel(glyph_i.glyph_left, glyph_i.glyph_byte[7:4], 1'b0);
        predict_pixel(glyph_i.glyph_left, glyph_i.glyph_byte[3:0], 1'b1);
      end

      pending_o = expected_pixels.size();
    end
  end

endmodule

// File: verif/glyph_pixel_blend_rgb565_core_tb.sv
// testbench top for the glyph pixel blender: drives glyph bytes and config, gives the verdict
module glyph_pixel_blend_rgb565_core_tb;
  import gpb_pkg::*;

  // cycles with no beat and no config access before the run is declared hung
  localparam int unsigned QuietLimit = 2000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned pixels_checked;

  // pacing knobs, changed between phases, and run counters
  int unsigned gap_max;
  int unsigned stall_max;
  int unsigned burst_left;
  int unsigned bytes_sent;
  int unsigned settings_used;
  int unsigned quiet_cycles;

  gpb_in_if  glyph_bus ();
  gpb_out_if pixel_bus ();

  glyph_pixel_blend_rgb565_core #(
    .MAX_GLYPH_WIDTH(64)
  ) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .glyph_i(glyph_bus),
    .pixel_o(pixel_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  gpb_pixel_check #(
    .MAX_GLYPH_WIDTH(64)
  ) u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .glyph_i         (glyph_bus),
    .pixel_i         (pixel_bus),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_count_o(mismatches),
    .pending_o       (pending),
    .pixels_checked_o(pixels_checked)
  );

  always #10 clk = ~clk;

  // receiver: random ready runs broken by random stalls, their length bounded by stall_max;
  // stall_max of zero keeps ready high
  logic        rdy_state = 1'b0;
  int unsigned rdy_hold  = 0;

  always @(negedge clk) begin
    if (rdy_hold != 0) begin
      rdy_hold--;
    end else if (rdy_state && stall_max != 0) begin
      rdy_state = 1'b0;
      rdy_hold  = $urandom_range(0, stall_max - 1);
    end else begin
      rdy_state = 1'b1;
      rdy_hold  = $urandom_range(0, 7);
    end
    pixel_bus.ready <= rdy_state;
  end

  // hang detector: any beat or config access restarts the count
  always @(posedge clk) begin
    if (!rst_n || (glyph_bus.valid && glyph_bus.ready) ||
        (pixel_bus.valid && pixel_bus.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("glyph_pixel_blend_rgb565_core_tb: done, errors");
        $finish;
      end
    end
  end

  // apb write: setup phase, then access phase, taken at a rising edge with pready high
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one glyph beat; opens a new burst when the current one runs out, after a random gap unless gap_max is zero
  task automatic send_byte(input logic [7:0] b, input logic s, input logic [8:0] left);
    int unsigned gap;
    if (burst_left == 0) begin
      if (gap_max == 0) begin
        burst_left = 32'h4000_0000;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(1, gap_max);
        // garbage on the payload while valid is low
        repeat (gap) begin
          @(negedge clk);
          glyph_bus.valid       <= 1'b0;
          glyph_bus.glyph_byte  <= 8'($urandom);
          glyph_bus.glyph_start <= 1'($urandom);
          glyph_bus.glyph_left  <= 9'($urandom);
        end
      end
    end
    burst_left--;
    @(negedge clk);
    glyph_bus.valid       <= 1'b1;
    glyph_bus.glyph_byte  <= b;
    glyph_bus.glyph_start <= s;
    glyph_bus.glyph_left  <= left;
    @(posedge clk);
    while (!glyph_bus.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // hold the sender until every predicted pixel has come back; sampled on the falling
  // edge so the checker has already settled the rising-edge beats
  task automatic drain_pixels();
    @(negedge clk);
    glyph_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_pace(input int unsigned gap, input int unsigned stall);
    gap_max    = gap;
    stall_max  = stall;
    burst_left = 0;
  endtask

  // mostly random coverage bytes, with the all-clear / all-set nibble pairs now and then
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 19))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h0F;
      3:       return 8'hF0;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [8:0] pick_left();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd511;
      default: return 9'($urandom);
    endcase
  endfunction

  // new colors, width and text row; upper data bits carry noise the registers must drop
  task automatic random_config();
    logic [15:0] fg;
    logic [15:0] bg;
    logic [6:0]  w;
    logic [8:0]  row0;
    case ($urandom_range(0, 4))
      0:       fg = 16'h0000;
      1:       fg = 16'hFFFF;
      default: fg = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       bg = 16'h0000;
      1:       bg = 16'hFFFF;
      default: bg = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       w = 7'd0;                       // acts as width 1
      1:       w = 7'd1;
      2:       w = 7'd64;
      3:       w = 7'd127;                     // clamped to the maximum
      4:       w = 7'($urandom_range(65, 126));
      default: w = 7'($urandom_range(2, 63));
    endcase
    case ($urandom_range(0, 4))
      0:       row0 = 9'd0;
      1:       row0 = 9'd511;
      default: row0 = 9'($urandom);
    endcase
    apb_write(REG_FG,    {16'($urandom), fg});
    apb_write(REG_BG,    {16'($urandom), bg});
    apb_write(REG_WIDTH, {25'($urandom), w});
    apb_write(REG_TOP,   {23'($urandom), row0});
    settings_used++;
  endtask

  // mostly well-formed glyphs (start on the first byte, fixed left edge), some loose bytes,
  // and now and then a full stop until the pixel side is empty
  task automatic random_traffic(input int unsigned items);
    int unsigned n;
    int unsigned len;
    int unsigned i;
    logic [8:0]  left;
    n = 0;
    while (n < items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_byte(pick_byte(), 1'($urandom_range(0, 1)), 9'($urandom));
        n++;
      end else begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 12);
        left = pick_left();
        for (i = 0; i < len && n < items; i++) begin
          send_byte(pick_byte(), i == 0, left);
          n++;
        end
      end
      if ($urandom_range(0, 39) == 0) drain_pixels();
    end
  endtask

  initial begin
    int unsigned phase;
    rst_n                 = 1'b0;
    glyph_bus.valid       = 1'b0;
    glyph_bus.glyph_byte  = '0;
    glyph_bus.glyph_start = 1'b0;
    glyph_bus.glyph_left  = '0;
    pixel_bus.ready       = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    bytes_sent            = 0;
    settings_used         = 1;
    set_pace(0, 0);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset colors (white on black, width 8): full and zero coverage on both nibbles,
    // eight pixels fill the first row, then a start byte restarts the glyph at left 511
    send_byte(8'h0F, 1'b1, 9'd0);
    send_byte(8'hF0, 1'b0, 9'd0);
    send_byte(8'h00, 1'b0, 9'd0);
    send_byte(8'hFF, 1'b0, 9'd0);
    send_byte(8'h5A, 1'b1, 9'd511);
    send_byte(8'hA5, 1'b0, 9'd511);

    // inverted colors, glyph one pixel wide starting at left and top 511, their largest values
    drain_pixels();
    apb_write(REG_FG,    32'h0000_0000);
    apb_write(REG_BG,    32'h0000_FFFF);
    apb_write(REG_WIDTH, 32'd1);
    apb_write(REG_TOP,   32'd511);
    settings_used++;
    send_byte(8'h7E, 1'b1, 9'd511);
    send_byte(8'h18, 1'b0, 9'd0);
    send_byte(8'hC3, 1'b0, 9'd256);

    // width zero walks like width one
    drain_pixels();
    apb_write(REG_WIDTH, 32'd0);
    settings_used++;
    send_byte(8'h12, 1'b1, 9'd5);
    send_byte(8'h34, 1'b0, 9'd5);

    // width beyond the maximum, pure red over pure green
    drain_pixels();
    apb_write(REG_WIDTH, 32'd127);
    apb_write(REG_FG,    32'h0000_F800);
    apb_write(REG_BG,    32'h0000_07E0);
    apb_write(REG_TOP,   32'd0);
    settings_used++;
    send_byte(8'h9C, 1'b1, 9'd100);
    send_byte(8'h63, 1'b0, 9'd100);

    // column already past a newly narrowed width wraps at once
    drain_pixels();
    apb_write(REG_WIDTH, 32'd8);
    settings_used++;
    send_byte(8'h11, 1'b1, 9'd40);
    send_byte(8'h22, 1'b0, 9'd40);
    send_byte(8'h33, 1'b0, 9'd40);
    drain_pixels();
    apb_write(REG_WIDTH, 32'd4);
    settings_used++;
    send_byte(8'h44, 1'b0, 9'd40);
    send_byte(8'h55, 1'b0, 9'd40);

    // random phases; two of them run with no idling on either side
    for (phase = 0; phase < 14; phase++) begin
      drain_pixels();
      random_config();
      if (phase == 0 || phase == 7) begin
        set_pace(0, 0);
      end else begin
        case ($urandom_range(0, 3))
          0: set_pace(0, 12);
          1: set_pace(2, 1);
          2: set_pace(6, 4);
          default: set_pace(14, 12);
        endcase
      end
      random_traffic(110);
    end

    // one long glyph of width one: the row offset runs past 511 and wraps
    drain_pixels();
    apb_write(REG_WIDTH, 32'd1);
    apb_write(REG_TOP,   32'd511);
    settings_used++;
    set_pace(3, 4);
    for (phase = 0; phase < 260; phase++) send_byte(pick_byte(), phase == 0, 9'd511);

    drain_pixels();
    repeat (8) @(negedge clk);

    $display("run: %0d glyph bytes under %0d register settings, %0d pixel beats compared",
             bytes_sent, settings_used, pixels_checked);
    $display("run: color extremes, width 0 and above 64, narrowed width mid-glyph, row wrap");
    if (mismatches == 0 && pending == 0) begin
      $display("glyph_pixel_blend_rgb565_core_tb: done, clean");
    end else begin
      $display("glyph_pixel_blend_rgb565_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/gpb_pkg.sv
hdl/gpb_if.sv
hdl/gpb_lane.sv
hdl/gpb_merge.sv
hdl/glyph_pixel_blend_rgb565_core.sv
hdl/gpb_checker.sv
verif/gpb_pixel_check.sv
verif/glyph_pixel_blend_rgb565_core_tb.sv
